// File: hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared widths, request and status codes, and the controller/datapath
// command and status types of the LIFO stack with sorted insert.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned REQ_W             = 2;
  localparam int unsigned STAT_W            = 2;
  localparam int unsigned OCC_W             = 5;
  localparam int unsigned DEF_STACK_DEPTH   = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Load source for the A pointer (insert position / reverse low index)
  typedef enum logic [1:0] {
    A_HOLD,
    A_CNT,
    A_CNT_M1,
    A_ZERO
  } a_sel_e;

  // Read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_A,
    RD_A_M1,
    RD_B
  } rd_sel_e;

  // Write address / data select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_A_VAL,
    WR_A_RDATA,
    WR_B_TMP
  } wr_sel_e;

  // Kind of result to load into the output register
  typedef enum logic [1:0] {
    RES_OK,
    RES_POP,
    RES_OVF,
    RES_UNF
  } res_sel_e;

  typedef struct packed {
    logic     val_load;   // capture the request value
    a_sel_e   a_sel;
    logic     a_inc;
    logic     a_dec;
    logic     b_load;     // B <= count - 1
    logic     b_dec;
    rd_sel_e  rd_sel;
    logic     tmp_load;   // tmp <= read data
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic lt2;        // fewer than two entries
    logic a_zero;
    logic a_lt_b;
    logic gt;         // read data greater than request value (signed)
  } sts_t;

endpackage

// File: hdl/lss_if.sv
// ----------------------------------------------------------------------------
// lss_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface lss_req_if
  import lss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface lss_rsp_if
  import lss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

// File: hdl/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// Request sequencer: decodes one request at a time and steps the datapath
// through push, pop, reverse swaps and the insert shift loop.
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PUSH      = 4'd1;
  localparam logic [3:0] ST_POP_RD    = 4'd2;
  localparam logic [3:0] ST_INS_CHK   = 4'd3;
  localparam logic [3:0] ST_INS_CMP   = 4'd4;
  localparam logic [3:0] ST_REV_CHK   = 4'd5;
  localparam logic [3:0] ST_REV_RD_LO = 4'd6;
  localparam logic [3:0] ST_REV_RD_HI = 4'd7;
  localparam logic [3:0] ST_REV_WR_LO = 4'd8;
  localparam logic [3:0] ST_REV_WR_HI = 4'd9;
  localparam logic [3:0] ST_FIN_OK    = 4'd10;
  localparam logic [3:0] ST_FIN_POP   = 4'd11;
  localparam logic [3:0] ST_FIN_OVF   = 4'd12;
  localparam logic [3:0] ST_FIN_UNF   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{a_sel: A_HOLD, rd_sel: RD_NONE, wr_sel: WR_NONE, res_sel: RES_OK,
                default: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.val_load = 1'b1;
          unique case (req_type_i)
            REQ_PUSH: begin
              cmd_o.a_sel = A_CNT;
              state_d     = sts_i.full ? ST_FIN_OVF : ST_PUSH;
            end
            REQ_POP: begin
              cmd_o.a_sel = A_CNT_M1;
              state_d     = sts_i.empty ? ST_FIN_UNF : ST_POP_RD;
            end
            REQ_REVERSE: begin
              cmd_o.a_sel  = A_ZERO;
              cmd_o.b_load = 1'b1;
              state_d      = sts_i.lt2 ? ST_FIN_OK : ST_REV_CHK;
            end
            REQ_INSERT: begin
              cmd_o.a_sel = A_CNT;
              state_d     = sts_i.full ? ST_FIN_OVF : ST_INS_CHK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH: begin
        cmd_o.wr_sel  = WR_A_VAL;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ST_FIN_OK;
      end
      ST_POP_RD: begin
        cmd_o.rd_sel  = RD_A;
        cmd_o.cnt_dec = 1'b1;
        state_d       = ST_FIN_POP;
      end
      // Insert: walk down while the entry below the hole is greater
      ST_INS_CHK: begin
        if (sts_i.a_zero) begin
          cmd_o.wr_sel  = WR_A_VAL;
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_FIN_OK;
        end else begin
          cmd_o.rd_sel = RD_A_M1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.gt) begin
          cmd_o.wr_sel = WR_A_RDATA;
          cmd_o.a_dec  = 1'b1;
          state_d      = ST_INS_CHK;
        end else begin
          cmd_o.wr_sel  = WR_A_VAL;
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_FIN_OK;
        end
      end
      // Reverse: swap low and high entries until the pointers meet
      ST_REV_CHK: begin
        state_d = sts_i.a_lt_b ? ST_REV_RD_LO : ST_FIN_OK;
      end
      ST_REV_RD_LO: begin
        cmd_o.rd_sel = RD_A;
        state_d      = ST_REV_RD_HI;
      end
      ST_REV_RD_HI: begin
        cmd_o.rd_sel   = RD_B;
        cmd_o.tmp_load = 1'b1;
        state_d        = ST_REV_WR_LO;
      end
      ST_REV_WR_LO: begin
        cmd_o.wr_sel = WR_A_RDATA;
        state_d      = ST_REV_WR_HI;
      end
      ST_REV_WR_HI: begin
        cmd_o.wr_sel = WR_B_TMP;
        cmd_o.a_inc  = 1'b1;
        cmd_o.b_dec  = 1'b1;
        state_d      = ST_REV_CHK;
      end
      // Result load, held until the output register is free
      ST_FIN_OK, ST_FIN_POP, ST_FIN_OVF, ST_FIN_UNF: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
          priority if (state_q == ST_FIN_POP) cmd_o.res_sel = RES_POP;
          else if (state_q == ST_FIN_OVF)     cmd_o.res_sel = RES_OVF;
          else if (state_q == ST_FIN_UNF)     cmd_o.res_sel = RES_UNF;
          else                                cmd_o.res_sel = RES_OK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (cmd_o.res_load)             rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Assertions
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted request did not start work");

  a_rev_ptrs_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REV_RD_LO) |-> sts_i.a_lt_b)
    else $error("reverse swap with crossed pointers");

  a_ins_cmp_not_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_CMP) |-> !sts_i.a_zero)
    else $error("insert compare below the bottom of the stack");

endmodule

// File: hdl/lss_dp.sv
// ----------------------------------------------------------------------------
// lss_dp
// Stack datapath: entry memory, entry count, walk pointers, value and swap
// holding registers, and the result register.
// ----------------------------------------------------------------------------
module lss_dp
  import lss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0]        mem_q [STACK_DEPTH];
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            a_q, a_d;
  logic [AW-1:0]            b_q, b_d;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0]        tmp_q;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [31:0]              cnt_ext;

  assign cnt_m1  = cnt_q - 1'b1;
  assign cnt_ext = 32'(cnt_q);

  // Status to the controller
  assign sts_o.empty  = (cnt_q == '0);
  assign sts_o.full   = (cnt_q == CW'(STACK_DEPTH));
  assign sts_o.lt2    = (cnt_q < CW'(2));
  assign sts_o.a_zero = (a_q == '0);
  assign sts_o.a_lt_b = (a_q < b_q);
  assign sts_o.gt     = (rdata_q > val_q);

  // Entry count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc)      cnt_d = cnt_q + 1'b1;
    else if (cmd_i.cnt_dec) cnt_d = cnt_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // Walk pointers
  always_comb begin
    a_d = a_q;
    unique case (cmd_i.a_sel)
      A_CNT:    a_d = cnt_q[AW-1:0];
      A_CNT_M1: a_d = cnt_m1[AW-1:0];
      A_ZERO:   a_d = '0;
      default: begin
        if (cmd_i.a_inc)      a_d = a_q + 1'b1;
        else if (cmd_i.a_dec) a_d = a_q - 1'b1;
      end
    endcase
    b_d = b_q;
    if (cmd_i.b_load)     b_d = cnt_m1[AW-1:0];
    else if (cmd_i.b_dec) b_d = b_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (cmd_i.val_load) val_q <= data_value_i;
    if (cmd_i.tmp_load) tmp_q <= rdata_q;
  end

  // Memory port selects
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = a_q;
    unique case (cmd_i.rd_sel)
      RD_A:    rd_addr = a_q;
      RD_A_M1: rd_addr = a_q - 1'b1;
      RD_B:    rd_addr = b_q;
      default: rd_en   = 1'b0;
    endcase
    wr_en   = 1'b1;
    wr_addr = a_q;
    wr_data = val_q;
    unique case (cmd_i.wr_sel)
      WR_A_VAL:   wr_data = val_q;
      WR_A_RDATA: wr_data = rdata_q;
      WR_B_TMP: begin
        wr_addr = b_q;
        wr_data = tmp_q;
      end
      default:    wr_en   = 1'b0;
    endcase
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      occupancy_o <= cnt_ext[OCC_W-1:0];
      unique case (cmd_i.res_sel)
        RES_POP: begin
          popped_value_o <= rdata_q;
          status_o       <= STAT_OK;
        end
        RES_OVF: begin
          popped_value_o <= '0;
          status_o       <= STAT_OVERFLOW;
        end
        RES_UNF: begin
          popped_value_o <= '1;
          status_o       <= STAT_UNDERFLOW;
        end
        default: begin
          popped_value_o <= '0;
          status_o       <= STAT_OK;
        end
      endcase
    end
  end

  // Assertions
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_no_inc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !sts_o.full)
    else $error("count increment on a full stack");

  a_no_dec_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> !sts_o.empty)
    else $error("count decrement on an empty stack");

endmodule

// File: hdl/lifo_stack_sorted_insert.sv
// Each request steps through controller states, one memory access per step: push
// writes the entry, pop reads it, insert moves each greater entry up before writing,
// reverse swaps pairs; rejected requests and reverse of fewer than two entries go
// straight to the result load. One request in flight; the next one is taken in the
// cycle after the result is loaded, even while that result waits in the output register.
// Reset (rst_ni low, asynchronous) empties the stack; no memory clearing pass.
// ----------------------------------------------------------------------------
// lifo_stack_sorted_insert
// Bounded LIFO stack of signed words with push, pop, reverse and ascending
// insert; controller sequences a datapath holding the entry memory.
// ----------------------------------------------------------------------------
module lifo_stack_sorted_insert
  import lss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lss_req_if.sink   req_i,
  lss_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lss_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_value_i   (req_i.data_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .popped_value_o (rsp_o.popped_value),
    .status_o       (rsp_o.status),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule

// File: tb/sv/lss_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_stack_checker
// Watches the request and result channels of the sorted-insert stack, keeps
// a shadow copy of the stack contents, predicts the result of every accepted
// request and compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module lss_stack_checker
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lss_req_if          req_i,
  lss_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
  } stack_result_t;

  // shadow stack; entry 0 is the bottom
  logic signed [DATA_W-1:0] shadow_mem [DEPTH];
  int                       shadow_fill = 0;
  stack_result_t            result_queue [$];
  int unsigned              mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] stack mismatch: %s", $realtime, msg);
    end
  endtask

  // Apply one request to the shadow stack and return the result it yields
  function automatic stack_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                  input logic signed [DATA_W-1:0] value);
    stack_result_t            res;
    int                       pos;
    int                       lo;
    int                       hi;
    logic signed [DATA_W-1:0] swap;
    res.popped_value = '0;
    res.status       = STAT_OK;
    case (kind)
      REQ_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = STAT_OVERFLOW;
        end else begin
          shadow_mem[shadow_fill] = value;
          shadow_fill++;
        end
      end
      REQ_POP: begin
        if (shadow_fill == 0) begin
          res.popped_value = -1;
          res.status       = STAT_UNDERFLOW;
        end else begin
          shadow_fill--;
          res.popped_value = shadow_mem[shadow_fill];
        end
      end
      REQ_REVERSE: begin
        lo = 0;
        hi = shadow_fill - 1;
        while (lo < hi) begin
          swap           = shadow_mem[lo];
          shadow_mem[lo] = shadow_mem[hi];
          shadow_mem[hi] = swap;
          lo++;
          hi--;
        end
      end
      REQ_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          res.status = STAT_OVERFLOW;
        end else begin
          // only the unbroken run of greater entries at the top moves up
          pos = shadow_fill;
          while (pos > 0 && shadow_mem[pos-1] > value) begin
            shadow_mem[pos] = shadow_mem[pos-1];
            pos--;
          end
          shadow_mem[pos] = value;
          shadow_fill++;
        end
      end
    endcase
    res.occupancy = shadow_fill[OCC_W-1:0];
    return res;
  endfunction

  // Result transactions are checked before the same edge's request is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      result_queue.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_queue.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding (popped %0d status %0d occ %0d)",
                                    rsp_i.popped_value, rsp_i.status, rsp_i.occupancy));
        end else begin
          want = result_queue.pop_front();
          if (rsp_i.popped_value !== want.popped_value) begin
            report_mismatch($sformatf("popped_value got %0d want %0d",
                                      rsp_i.popped_value, want.popped_value));
          end
          if (rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", rsp_i.status, want.status));
          end
          if (rsp_i.occupancy !== want.occupancy) begin
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      rsp_i.occupancy, want.occupancy));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        result_queue.push_back(apply_request(req_i.req_type, req_i.data_value));
      end
      pending_o    <= result_queue.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/sv/lifo_stack_sorted_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_sorted_insert_test
// Drives push, pop, reverse and sorted-insert requests into the stack: a
// directed opening over the corner cases, then biased random traffic that
// fills and drains the stack, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module lifo_stack_sorted_insert_test;
  import lss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned QUIET_FIRST  = 900;
  localparam int unsigned QUIET_LAST   = 1300;
  localparam int unsigned IDLE_PCT     = 6;
  localparam int unsigned TAIL_CYCLES  = 60;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_DRAIN,
    MIX_SORTED
  } traffic_mix_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  logic        quiet;

  lss_req_if req_ch ();
  lss_rsp_if rsp_ch ();

  lifo_stack_sorted_insert #(
    .STACK_DEPTH(DEF_STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  lss_stack_checker #(
    .DEPTH(DEF_STACK_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // no idling on either side inside this window of transactions
  assign quiet = (sent_count >= QUIET_FIRST) && (sent_count < QUIET_LAST);

  // result side back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // many small values so equal keys and short moves are common
  function automatic logic signed [DATA_W-1:0] random_value();
    logic signed [DATA_W-1:0] corner [4];
    corner[0] = 32'sh7FFF_FFFF;
    corner[1] = 32'sh8000_0000;
    corner[2] = '0;
    corner[3] = -1;
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom_range(20)) - 10;
      4:          return corner[$urandom_range(3)];
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(input traffic_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_GROW:
        return roll < 40 ? REQ_PUSH : roll < 70 ? REQ_INSERT : roll < 90 ? REQ_POP : REQ_REVERSE;
      MIX_DRAIN:
        return roll < 60 ? REQ_POP : roll < 75 ? REQ_PUSH : roll < 90 ? REQ_INSERT : REQ_REVERSE;
      default:
        return roll < 60 ? REQ_INSERT : roll < 90 ? REQ_POP : REQ_REVERSE;
    endcase
  endfunction

  // One request transaction, with an occasional idle gap before it
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_W'($urandom);
      req_ch.data_value <= $urandom;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.data_value <= value;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_count++;
  endtask

  initial begin
    traffic_mix_e mix;
    int unsigned  mix_left;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PUSH;
    req_ch.data_value = '0;
    rsp_ch.ready      = 1'b0;
    mix               = MIX_GROW;
    mix_left          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stack, signed extremes, equal keys, unsorted insert
    send_request(REQ_POP, '0);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_PUSH, 32'sh7FFF_FFFF);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, -1);
    send_request(REQ_PUSH, '0);
    send_request(REQ_PUSH, 100);
    send_request(REQ_INSERT, 50);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_POP, '0);
    // fill up, then hit the full stack
    repeat (10) send_request(REQ_PUSH, random_value());
    send_request(REQ_PUSH, 32'sh1234_5678);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_REVERSE, '0);

    // random: segments that grow, drain or insert in order
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (mix_left == 0) begin
        mix      = traffic_mix_e'($urandom_range(2));
        mix_left = $urandom_range(60, 10);
      end
      mix_left--;
      send_request(pick_request(mix), random_value());
    end
    req_ch.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
